// ===== rtl/hmg16_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hmg16_pkg
// Shared constants, opcodes, state type and controller/datapath bundles for
// the height grid to 16-bit grayscale normalizer.
// ----------------------------------------------------------------------------
package hmg16_pkg;

    localparam int GRID_SIDE = 65;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;

    localparam int OP_W   = 2;
    localparam int IDX_W  = 13;
    localparam int H_W    = 24;
    localparam int GRAY_W = 16;
    localparam int CNT_W  = $clog2(GRAY_W);
    localparam int NUM_W  = H_W + GRAY_W;

    localparam logic [IDX_W:0]   CELLS_EXT = (IDX_W + 1)'(CELLS);
    localparam logic [GRAY_W-1:0] GRAY_FULL = {GRAY_W{1'b1}};
    localparam logic signed [H_W-1:0] H_MAX = {1'b0, {(H_W-1){1'b1}}};
    localparam logic signed [H_W-1:0] H_MIN = {1'b1, {(H_W-1){1'b0}}};

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_INIT,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clr;
        logic wr;
        logic rd;
        logic load;
        logic init;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic special;
    } status_t;

endpackage
`default_nettype wire

// ===== rtl/hmg16_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hmg16_datapath
// Height store, running extremes, range checks and a restoring divider that
// yields one quotient bit per step.
// ----------------------------------------------------------------------------
module hmg16_datapath
    import hmg16_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmd_t                     cmd,
    input  wire logic [IDX_W-1:0]         grid_index,
    input  wire logic signed [H_W-1:0]    height,
    output status_t                       status,
    output logic [GRAY_W-1:0]             gray_value
);

    logic signed [H_W-1:0] height_mem [0:CELLS-1];

    logic signed [H_W-1:0] min_reg;
    logic signed [H_W-1:0] max_reg;
    logic signed [H_W-1:0] rd_data_reg;
    logic                  oor_reg;
    logic                  special_reg;
    logic                  special_next;
    logic                  full_reg;
    logic                  full_next;
    logic [H_W-1:0]        diff_reg;
    logic [H_W-1:0]        span_reg;
    logic [H_W-1:0]        rem_reg;
    logic [H_W-1:0]        rem_next;
    logic [GRAY_W-1:0]     quo_reg;
    logic [GRAY_W-1:0]     quo_next;

    logic                  in_range;
    logic signed [H_W:0]   diff_w;
    logic signed [H_W:0]   span_w;
    logic [NUM_W-1:0]      num_w;
    logic [H_W:0]          shifted_w;
    logic [H_W+1:0]        trial_w;
    logic                  ge_w;

    assign in_range = ({1'b0, grid_index} < CELLS_EXT);

    always_ff @(posedge clk)
    begin
        if (cmd.wr && in_range)
        begin
            height_mem[grid_index] <= height;
        end
        if (cmd.rd && in_range)
        begin
            rd_data_reg <= height_mem[grid_index];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= H_MAX;
            max_reg <= H_MIN;
        end
        else if (cmd.clr)
        begin
            min_reg <= H_MAX;
            max_reg <= H_MIN;
        end
        else if (cmd.wr && in_range)
        begin
            if (height < min_reg)
            begin
                min_reg <= height;
            end
            if (height > max_reg)
            begin
                max_reg <= height;
            end
        end
    end

    // classify the read word against the frame extremes
    always_comb
    begin
        diff_w = {rd_data_reg[H_W-1], rd_data_reg} - {min_reg[H_W-1], min_reg};
        span_w = {max_reg[H_W-1], max_reg} - {min_reg[H_W-1], min_reg};
        special_next = 1'b1;
        full_next    = 1'b0;
        if (oor_reg || (max_reg <= min_reg) || (rd_data_reg <= min_reg))
        begin
            special_next = 1'b1;
        end
        else if (rd_data_reg >= max_reg)
        begin
            full_next = 1'b1;
        end
        else
        begin
            special_next = 1'b0;
        end
    end

    // scaled numerator: diff * 65535 = (diff << 16) - diff
    assign num_w = {diff_reg, {GRAY_W{1'b0}}} - {{GRAY_W{1'b0}}, diff_reg};

    always_comb
    begin
        shifted_w = {rem_reg, quo_reg[GRAY_W-1]};
        trial_w   = {1'b0, shifted_w} - {2'b00, span_reg};
        ge_w      = !trial_w[H_W+1];
        rem_next  = ge_w ? trial_w[H_W-1:0] : shifted_w[H_W-1:0];
        quo_next  = {quo_reg[GRAY_W-2:0], ge_w};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            oor_reg <= !in_range;
        end
        if (cmd.load)
        begin
            special_reg <= special_next;
            full_reg    <= full_next;
            diff_reg    <= diff_w[H_W-1:0];
            span_reg    <= span_w[H_W-1:0];
        end
        if (cmd.init)
        begin
            rem_reg <= num_w[NUM_W-1:GRAY_W];
            quo_reg <= num_w[GRAY_W-1:0];
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign status.special = special_reg;
    assign gray_value = special_reg ? (full_reg ? GRAY_FULL : '0) : quo_reg;

endmodule
`default_nettype wire

// ===== rtl/hmg16_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hmg16_ctrl
// Sequencer: takes command words, steps the datapath through fetch, classify,
// numerator setup and the divide iterations, and strobes the result.
// ----------------------------------------------------------------------------
module hmg16_ctrl
    import hmg16_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [OP_W-1:0]   opcode,
    input  wire status_t           status,
    output cmd_t                   cmd,
    output logic                   busy,
    output logic                   done
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             accept;
    logic             last_step;

    assign accept    = start && (state_reg == ST_IDLE);
    assign last_step = (cnt_reg == CNT_W'(GRAY_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (opcode == OP_READ))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cnt_next   = '0;
                state_next = status.special ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.clr  = accept && (opcode == OP_CLEAR);
                cmd.wr   = accept && (opcode == OP_WRITE);
                cmd.rd   = accept && (opcode == OP_READ);
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
            end
            ST_INIT:
            begin
                cmd.init = 1'b1;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    a_read_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_READ)) |=> busy)
        else $error("read word did not start a sequence");

    a_other_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode != OP_READ)) |=> !busy)
        else $error("non-read word made the block busy");

    a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && last_step) |=> done)
        else $error("divider finished without a result strobe");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe longer than one cycle");

endmodule
`default_nettype wire

// ===== rtl/heightmap_min_max_to_gray16_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_min_max_to_gray16_unit
// Normalizes a square grid of signed Q15.8 heights to 16-bit grayscale using
// the running minimum and maximum of the current frame.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (opcode, grid_index, height) is taken on a clock edge with
//   start high and busy low. Clear and write words complete at that edge;
//   busy stays low and the next word may follow in the next cycle.
//   A read word raises busy. The stored height is fetched and then
//   classified; flat, empty, out-of-range and clipped cases then strobe done
//   with gray_value. All other reads run a restoring divider at one quotient
//   bit per cycle and then strobe done; busy drops the cycle after, so a new
//   read is taken only once the previous one has finished.
//   done is high for exactly one cycle and gray_value is valid with it; the
//   receiver cannot stall and must take the word then. gray_value holds until
//   the next read reloads it. Unused opcode 3 is dropped.
//   Reset returns the sequencer to idle and sets the frame extremes to the
//   empty state; the height store keeps no reset value and needs no pass.
// ----------------------------------------------------------------------------
module heightmap_min_max_to_gray16_unit
    import hmg16_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [OP_W-1:0]       opcode,
    input  wire logic [IDX_W-1:0]      grid_index,
    input  wire logic signed [H_W-1:0] height,
    output logic                       done,
    output logic [GRAY_W-1:0]          gray_value
);

    cmd_t    cmd;
    status_t status;

    hmg16_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    hmg16_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .grid_index (grid_index),
        .height     (height),
        .status     (status),
        .gray_value (gray_value)
    );

endmodule
`default_nettype wire
